// ===== design/arp_request_builder_and_reply_filter_macros.svh =====
// Assertion macros shared by the ARP request builder and reply filter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ARP_REQUEST_BUILDER_AND_REPLY_FILTER_MACROS_SVH
`define ARP_REQUEST_BUILDER_AND_REPLY_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ARPRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("arprb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ARPRB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("arprb assertion failed");

`else

`define ARPRB_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ARPRB_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== design/arprb_pkg.sv =====
// Package for the ARP request builder and reply filter: types, constants and
// the per-position frame byte functions. No dependencies.
`default_nettype none

package arprb_pkg;

    localparam int BYTE_W          = 8;
    localparam int MAC_W           = 48;
    localparam int IP_W            = 32;
    localparam int REQUEST_BYTES   = 42;
    localparam int MAX_FRAME_BYTES_DEF = 1514;
    localparam int REQ_POS_W       = $clog2(REQUEST_BYTES);
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = MAC_W;
    localparam int M_TDATA_W       = 16;

    typedef logic [REQ_POS_W-1:0]   req_pos_t;
    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [MAC_W-1:0]       mac_t;
    typedef logic [IP_W-1:0]        ip_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    typedef enum logic {
        REQ_SEND = 1'b0,
        REQ_RX   = 1'b1
    } req_type_t;

    typedef enum logic {
        KIND_TX      = 1'b0,
        KIND_VERDICT = 1'b1
    } result_kind_t;

    localparam cfg_index_t CFG_OWN_MAC   = 2'd0;
    localparam cfg_index_t CFG_OWN_IP    = 2'd1;
    localparam cfg_index_t CFG_TARGET_IP = 2'd2;

    localparam byte_t BCAST_BYTE    = 8'hff;
    localparam byte_t ETYPE_ARP_HI  = 8'h08;
    localparam byte_t ETYPE_ARP_LO  = 8'h06;
    localparam byte_t HTYPE_HI      = 8'h00;
    localparam byte_t HTYPE_LO      = 8'h01;
    localparam byte_t PTYPE_HI      = 8'h08;
    localparam byte_t PTYPE_LO      = 8'h00;
    localparam byte_t HLEN_ETH      = 8'd6;
    localparam byte_t PLEN_IPV4     = 8'd4;
    localparam byte_t OPER_HI       = 8'h00;
    localparam byte_t OPER_REQUEST  = 8'h01;

    // One received byte handed from the input stage to the receive filter.
    typedef struct packed {
        logic  step;
        byte_t data;
        logic  last;
    } rx_beat_t;

    // Byte k of a MAC address, first byte most significant.
    function automatic byte_t mac_byte(input mac_t mac, input logic [2:0] k);
        return mac[(3'd5 - k) * 8 +: BYTE_W];
    endfunction

    // Byte k of an IPv4 address, first byte most significant.
    function automatic byte_t ip_byte(input ip_t ip, input logic [1:0] k);
        return ip[(2'd3 - k) * 8 +: BYTE_W];
    endfunction

    // Byte p of the outgoing ARP request in wire order.
    function automatic byte_t request_byte(input req_pos_t p, input mac_t mac,
                                           input ip_t own_ip, input ip_t tgt_ip);
        byte_t b;
        case (p) inside
            [6'd0:6'd5]:   b = BCAST_BYTE;
            [6'd6:6'd11]:  b = mac_byte(mac, 3'(p - 6'd6));
            6'd12:         b = ETYPE_ARP_HI;
            6'd13:         b = ETYPE_ARP_LO;
            6'd14:         b = HTYPE_HI;
            6'd15:         b = HTYPE_LO;
            6'd16:         b = PTYPE_HI;
            6'd17:         b = PTYPE_LO;
            6'd18:         b = HLEN_ETH;
            6'd19:         b = PLEN_IPV4;
            6'd20:         b = OPER_HI;
            6'd21:         b = OPER_REQUEST;
            [6'd22:6'd27]: b = mac_byte(mac, 3'(p - 6'd22));
            [6'd28:6'd31]: b = ip_byte(own_ip, 2'(p - 6'd28));
            [6'd38:6'd41]: b = ip_byte(tgt_ip, 2'(p - 6'd38));
            default:       b = '0;
        endcase
        return b;
    endfunction

    // True when received byte b at header position p agrees or is not checked.
    function automatic logic rx_byte_agrees(input req_pos_t p, input byte_t b,
                                            input mac_t mac, input ip_t own_ip,
                                            input ip_t tgt_ip);
        logic ok;
        case (p) inside
            [6'd0:6'd5]:   ok = (b == mac_byte(mac, 3'(p)));
            6'd12:         ok = (b == ETYPE_ARP_HI);
            6'd13:         ok = (b == ETYPE_ARP_LO);
            [6'd28:6'd31]: ok = (b == ip_byte(tgt_ip, 2'(p - 6'd28)));
            [6'd38:6'd41]: ok = (b == ip_byte(own_ip, 2'(p - 6'd38)));
            default:       ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/arprb_rx_filter.sv =====
// Receive side of the ARP reply filter: byte counter, header comparison and
// verdict for the frame that ends on the current beat. Depends on arprb_pkg.
`default_nettype none

module arprb_rx_filter #(
    parameter int MAX_FRAME_BYTES = arprb_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire arprb_pkg::mac_t    own_mac,
    input  wire arprb_pkg::ip_t     own_ip,
    input  wire arprb_pkg::ip_t     target_ip,
    input  wire arprb_pkg::rx_beat_t beat,
    output logic                    match
);

    localparam int RX_POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [RX_POS_W-1:0] rx_position_reg;
    logic [RX_POS_W-1:0] rx_position_next;
    logic                fields_agree_reg;
    logic                fields_agree_next;
    logic                in_header;

    assign in_header = rx_position_reg < RX_POS_W'(arprb_pkg::REQUEST_BYTES);

    always_comb begin
        fields_agree_next = fields_agree_reg;
        if (in_header && !arprb_pkg::rx_byte_agrees(
                rx_position_reg[arprb_pkg::REQ_POS_W-1:0], beat.data,
                own_mac, own_ip, target_ip)) begin
            fields_agree_next = 1'b0;
        end
        // The count stops at the largest frame size.
        if (rx_position_reg < RX_POS_W'(MAX_FRAME_BYTES)) begin
            rx_position_next = rx_position_reg + RX_POS_W'(1);
        end else begin
            rx_position_next = rx_position_reg;
        end
    end

    assign match = fields_agree_next &&
                   (rx_position_next >= RX_POS_W'(arprb_pkg::REQUEST_BYTES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_position_reg  <= '0;
            fields_agree_reg <= 1'b1;
        end else if (beat.step) begin
            if (beat.last) begin
                rx_position_reg  <= '0;
                fields_agree_reg <= 1'b1;
            end else begin
                rx_position_reg  <= rx_position_next;
                fields_agree_reg <= fields_agree_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/arp_request_builder_and_reply_filter.sv =====
// Channel  | Direction | Payload
// s_       | in        | tdata[7:0] rx_byte, tuser req_type, tlast rx_last
// m_       | out       | tdata[7:0] tx_byte, tdata[8] reply_match, tuser kind, tlast
// cfg_     | in        | cfg_index register number, cfg_data value
//
// A byte stream is accepted one beat per cycle while the input register is not held.
// A send request occupies the input register for 42 output beats, one per cycle
// while m_tready is high; the request byte counter sets that figure.
// Reset (aresetn, synchronous) empties both stages and zeroes the configuration and counter registers.
// A stalled output holds its beat; received bytes that do not end a frame keep
// flowing, while a request or the last byte of a frame waits in the input register.
// Top level of the ARP request builder and reply filter; uses arprb_pkg,
// arprb_rx_filter and the assertion macro header.
`default_nettype none

`include "arp_request_builder_and_reply_filter_macros.svh"

module arp_request_builder_and_reply_filter #(
    parameter int MAX_FRAME_BYTES = arprb_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [arprb_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] rx_byte
    input  wire logic                               s_tuser,  // [0] req_type
    input  wire logic                               s_tlast,
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [arprb_pkg::M_TDATA_W-1:0]         m_tdata,  // [7:0] tx_byte, [8] reply_match
    output logic                                    m_tuser,  // [0] result_kind
    output logic                                    m_tlast,
    // Configuration writes.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [arprb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [arprb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam arprb_pkg::req_pos_t TX_FINAL_POS =
        arprb_pkg::REQ_POS_W'(arprb_pkg::REQUEST_BYTES - 1);

    arprb_pkg::mac_t         own_mac_reg;
    arprb_pkg::ip_t          own_ip_reg;
    arprb_pkg::ip_t          target_ip_reg;

    logic                    in_valid_reg;
    arprb_pkg::req_type_t    in_type_reg;
    arprb_pkg::byte_t        in_byte_reg;
    logic                    in_last_reg;

    arprb_pkg::req_pos_t     tx_pos_reg;
    arprb_pkg::req_pos_t     tx_pos_next;

    logic                    out_valid_reg;
    arprb_pkg::result_kind_t out_kind_reg;
    arprb_pkg::byte_t        out_byte_reg;
    logic                    out_last_reg;
    logic                    out_match_reg;

    logic                    out_free;
    logic                    is_send;
    logic                    tx_final;
    logic                    out_load;
    logic                    in_advance;
    logic                    in_take;
    logic                    rx_match;
    arprb_pkg::rx_beat_t     rx_beat;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg   <= '0;
            own_ip_reg    <= '0;
            target_ip_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                arprb_pkg::CFG_OWN_MAC:   own_mac_reg   <= cfg_data;
                arprb_pkg::CFG_OWN_IP:    own_ip_reg    <= cfg_data[arprb_pkg::IP_W-1:0];
                arprb_pkg::CFG_TARGET_IP: target_ip_reg <= cfg_data[arprb_pkg::IP_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake between input register and output register.
    assign out_free = !out_valid_reg || m_tready;
    assign is_send  = (in_type_reg == arprb_pkg::REQ_SEND);
    assign tx_final = (tx_pos_reg == TX_FINAL_POS);
    assign out_load = in_valid_reg && out_free && (is_send || in_last_reg);

    // A request leaves the input register with its last byte; a received byte
    // leaves at once unless it ends a frame and the verdict has no room yet.
    always_comb begin
        if (!in_valid_reg) begin
            in_advance = 1'b0;
        end else if (is_send) begin
            in_advance = out_free && tx_final;
        end else begin
            in_advance = !in_last_reg || out_free;
        end
    end

    assign s_tready = !in_valid_reg || in_advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        tx_pos_next = tx_pos_reg;
        if (out_load && is_send) begin
            tx_pos_next = tx_final ? '0 : tx_pos_reg + arprb_pkg::REQ_POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            tx_pos_reg   <= '0;
        end else begin
            tx_pos_reg <= tx_pos_next;
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (in_advance) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_type_reg <= arprb_pkg::req_type_t'(s_tuser);
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Receive filter.
    always_comb begin
        rx_beat.step = in_valid_reg && !is_send && in_advance;
        rx_beat.data = in_byte_reg;
        rx_beat.last = in_last_reg;
    end

    arprb_rx_filter #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_rx_filter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .own_mac  (own_mac_reg),
        .own_ip   (own_ip_reg),
        .target_ip(target_ip_reg),
        .beat     (rx_beat),
        .match    (rx_match)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (is_send) begin
                out_kind_reg  <= arprb_pkg::KIND_TX;
                out_byte_reg  <= arprb_pkg::request_byte(tx_pos_reg, own_mac_reg,
                                                         own_ip_reg, target_ip_reg);
                out_last_reg  <= tx_final;
                out_match_reg <= 1'b0;
            end else begin
                out_kind_reg  <= arprb_pkg::KIND_VERDICT;
                out_byte_reg  <= '0;
                out_last_reg  <= 1'b0;
                out_match_reg <= rx_match;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(arprb_pkg::M_TDATA_W - arprb_pkg::BYTE_W - 1){1'b0}},
                       out_match_reg, out_byte_reg};

    // Checks.
    `ARPRB_ASSERT_IMP(a_tx_pos_range, aclk, aresetn, 1'b1, tx_pos_reg <= TX_FINAL_POS)
    `ARPRB_ASSERT_IMP(a_tx_pos_owner, aclk, aresetn, tx_pos_reg != '0,
                      in_valid_reg && is_send)
    `ARPRB_ASSERT_IMP(a_verdict_clean, aclk, aresetn,
                      m_tvalid && (out_kind_reg == arprb_pkg::KIND_VERDICT),
                      (out_byte_reg == '0) && !out_last_reg)
    `ARPRB_ASSERT_IMP(a_tx_no_match, aclk, aresetn,
                      m_tvalid && (out_kind_reg == arprb_pkg::KIND_TX), !out_match_reg)
    `ARPRB_ASSERT_NXT(a_last_wraps, aclk, aresetn, out_load && is_send && tx_final,
                      tx_pos_reg == '0)

endmodule

`default_nettype wire
